/* src/stop_and_wait_crc_receiver_defines.svh */
// Assertion macros shared by the receiver's checker.
`ifndef STOP_AND_WAIT_CRC_RECEIVER_DEFINES_SVH
`define STOP_AND_WAIT_CRC_RECEIVER_DEFINES_SVH

// Same-cycle implication, off while reset is held.
`define SWCR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held.
`define SWCR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, live through reset.
`define SWCR_ASSERT_NEXT_RAW(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/swcr_pkg.sv */
// Shared types and constants of the stop-and-wait CRC receiver.
`default_nettype none

package swcr_pkg;

    localparam int CRC_WIDTH_DEF = 16;          // default divider width
    localparam int POLY_W        = 16;          // width of the generator register
    localparam logic [POLY_W-1:0] POLY_RESET = 16'h1021;   // CCITT, top bit implicit

    typedef enum logic [1:0] {
        FS_ACCEPTED     = 2'd0,
        FS_CRC_ERROR    = 2'd1,
        FS_SEQ_MISMATCH = 2'd2
    } t_frame_status;

    // Control from the frame tracker to the CRC cell row.
    typedef struct packed {
        logic shift;    // shift one body bit into the divider
        logic clear;    // end of frame: divider back to zero
    } t_crc_ctl;

    // One result beat.
    typedef struct packed {
        logic          ack_sent;
        logic          ack_seq;
        t_frame_status status;
    } t_result;

endpackage

`default_nettype wire

/* src/swcr_cell.sv */
// One bit cell of the serial CRC divider.
`default_nettype none

module swcr_cell (
    input  wire  i_clk,
    input  wire  i_shift_in,   // bit from the lower neighbor (or the line)
    input  wire  i_feedback,   // top bit of the divider
    input  wire  i_poly_bit,   // generator bit for this position
    input  wire  i_shift,
    input  wire  i_clear,
    output logic o_bit,        // stored bit
    output logic o_next        // value after a shift
);

    logic r_bit;
    logic n_bit;

    assign o_next = i_shift_in ^ (i_feedback & i_poly_bit);

    always_comb begin
        if (i_clear) begin
            n_bit = 1'b0;
        end else if (i_shift) begin
            n_bit = o_next;
        end else begin
            n_bit = r_bit;
        end
    end

    // divider state has no reset of its own; i_clear (frame end, or reset in the row) empties it
    always_ff @(posedge i_clk) begin
        r_bit <= n_bit;
    end

    assign o_bit = r_bit;

endmodule

`default_nettype wire

/* src/swcr_crc_row.sv */
// Row of CRC cells forming the serial divider, with a zero-remainder flag.
`default_nettype none

module swcr_crc_row
    import swcr_pkg::*;
#(
    parameter int CRC_WIDTH = CRC_WIDTH_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_bit_value,
    input  wire  [POLY_W-1:0] i_poly,
    input  t_crc_ctl          i_ctl,
    output logic              o_next_zero   // remainder after this shift is zero
);

    logic [CRC_WIDTH-1:0] w_bits;
    logic [CRC_WIDTH-1:0] w_next;
    logic                 w_clear;

    // reset empties the divider
    assign w_clear = i_ctl.clear | ~i_rst_n;

    genvar g;
    generate
        for (g = 0; g < CRC_WIDTH; g++) begin : g_cell
            logic w_in;
            logic w_poly;

            if (g == 0) begin : g_first
                assign w_in = i_bit_value;
            end else begin : g_link
                assign w_in = w_bits[g-1];
            end

            // generator bits above the register width are zero
            if (g < POLY_W) begin : g_pbit
                assign w_poly = i_poly[g];
            end else begin : g_pzero
                assign w_poly = 1'b0;
            end

            swcr_cell u_cell (
                .i_clk      (i_clk),
                .i_shift_in (w_in),
                .i_feedback (w_bits[CRC_WIDTH-1]),
                .i_poly_bit (w_poly),
                .i_shift    (i_ctl.shift),
                .i_clear    (w_clear),
                .o_bit      (w_bits[g]),
                .o_next     (w_next[g])
            );
        end
    endgenerate

    assign o_next_zero = ~|w_next;

endmodule

`default_nettype wire

/* src/swcr_frame_ctrl.sv */
// Frame tracker: sequence bit check, expected sequence and verdict.
`default_nettype none

module swcr_frame_ctrl
    import swcr_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_accept,
    input  wire      i_bit_value,
    input  wire      i_last_bit,
    input  wire      i_next_zero,
    output t_crc_ctl o_ctl,
    output logic     o_res_valid,
    output t_result  o_res
);

    logic r_expected_seq;
    logic r_at_start;
    logic r_seq_matched;
    logic n_expected_seq;
    logic n_at_start;
    logic n_seq_matched;

    logic w_matched;
    logic w_crc_ok;

    // on a single-bit frame the compare is taken straight from the line
    assign w_matched = r_at_start ? (i_bit_value == r_expected_seq) : r_seq_matched;
    // divider is already zero at frame start
    assign w_crc_ok  = r_at_start | i_next_zero;

    assign o_ctl.shift = i_accept & ~r_at_start;
    assign o_ctl.clear = i_accept & i_last_bit;
    assign o_res_valid = i_accept & i_last_bit;

    always_comb begin
        o_res.ack_sent = 1'b0;
        o_res.ack_seq  = 1'b0;
        o_res.status   = FS_SEQ_MISMATCH;
        if (w_matched && !w_crc_ok) begin
            o_res.status = FS_CRC_ERROR;
        end else if (w_matched) begin
            o_res.ack_sent = 1'b1;
            o_res.ack_seq  = r_expected_seq;
            o_res.status   = FS_ACCEPTED;
        end
    end

    always_comb begin
        n_expected_seq = r_expected_seq;
        n_at_start     = r_at_start;
        n_seq_matched  = r_seq_matched;
        if (i_accept) begin
            if (i_last_bit) begin
                n_at_start    = 1'b1;
                n_seq_matched = 1'b0;
                if (o_res.ack_sent) begin
                    n_expected_seq = ~r_expected_seq;
                end
            end else if (r_at_start) begin
                n_at_start    = 1'b0;
                n_seq_matched = w_matched;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_seq <= 1'b0;
            r_at_start     <= 1'b1;
            r_seq_matched  <= 1'b0;
        end else begin
            r_expected_seq <= n_expected_seq;
            r_at_start     <= n_at_start;
            r_seq_matched  <= n_seq_matched;
        end
    end

endmodule

`default_nettype wire

/* src/stop_and_wait_crc_receiver.sv */
// Top level of the stop-and-wait CRC receiver.
`default_nettype none

// Receiving end of an alternating-bit stop-and-wait link. Frame bits come in
// one per input beat; the first bit of each frame is its sequence bit and the
// rest (data, then CRC) shift through a row of CRC_WIDTH one-bit cells that
// divide by x^CRC_WIDTH + generator_poly, starting from zero. The beat that
// carries last_bit produces exactly one result beat: ACK with the expected
// sequence bit when the sequence matches and the remainder is zero (the
// expected bit then toggles), otherwise a CRC error or, taking priority, a
// sequence mismatch, with no ACK. Duplicates are not acknowledged again.
// Rate: one bit per clock, sustained; each cell updates with a single XOR
// per bit, and the remainder-zero check plus verdict fit in the same cycle.
// The result beat shows from an output register on the cycle after its last
// bit is taken, or waits in one skid entry while that register is held; input
// keeps flowing while a result waits and stalls only once both entries are full.
// Users write generator_poly via the config channel (always ready) only while
// the link is idle (block does not enforce); resets to 0x1021, masked to CRC_WIDTH.
module stop_and_wait_crc_receiver
    import swcr_pkg::*;
#(
    parameter int CRC_WIDTH = CRC_WIDTH_DEF   // 1 to 32
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    // bit input
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  wire               i_bit_value,
    input  wire               i_last_bit,
    // result output
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output logic              o_ack_sent,
    output logic              o_ack_seq,
    output logic [1:0]        o_frame_status,
    // generator register write
    input  wire               i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire  [POLY_W-1:0] i_cfg_data
);

    logic [POLY_W-1:0] r_poly;
    logic              w_accept;
    logic              w_next_zero;
    t_crc_ctl          w_ctl;
    logic              w_res_valid;
    t_result           w_res;

    // output register and skid entry
    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;
    logic    n_out_valid;
    t_result n_out;
    logic    n_skid_valid;
    t_result n_skid;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = ~r_skid_valid;
    assign w_accept    = i_in_valid & o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly <= POLY_RESET;
        end else if (i_cfg_valid) begin
            r_poly <= i_cfg_data;
        end
    end

    swcr_frame_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_bit_value (i_bit_value),
        .i_last_bit  (i_last_bit),
        .i_next_zero (w_next_zero),
        .o_ctl       (w_ctl),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    swcr_crc_row #(
        .CRC_WIDTH (CRC_WIDTH)
    ) u_row (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_bit_value (i_bit_value),
        .i_poly      (r_poly),
        .i_ctl       (w_ctl),
        .o_next_zero (w_next_zero)
    );

    // Skid handling: a new result goes to the skid entry only when the output
    // register is held; the skid drains first once the output frees up.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (r_out_valid && !i_out_ready) begin
            if (w_res_valid) begin
                n_skid_valid = 1'b1;
                n_skid       = w_res;
            end
        end else if (r_skid_valid) begin
            // input was stalled, so no new result this cycle
            n_out_valid  = 1'b1;
            n_out        = r_skid;
            n_skid_valid = 1'b0;
        end else begin
            n_out_valid = w_res_valid;
            n_out       = w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid    = r_out_valid;
    assign o_ack_sent     = r_out.ack_sent;
    assign o_ack_seq      = r_out.ack_seq;
    assign o_frame_status = r_out.status;

endmodule

`default_nettype wire

/* src/swcr_checker.sv */
// Port-level assertion checker for the receiver, bound to the top level.
`default_nettype none
`include "stop_and_wait_crc_receiver_defines.svh"

module swcr_checker
    import swcr_pkg::*;
(
    input wire              i_clk,
    input wire              i_rst_n,
    input wire              o_out_valid,
    input wire              i_out_ready,
    input wire              o_ack_sent,
    input wire              o_ack_seq,
    input wire [1:0]        o_frame_status
);

    // a held result beat keeps its payload
    `SWCR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_frame_status) && $stable(o_ack_sent) && $stable(o_ack_seq), "result beat changed while stalled")

    // ACK exactly on accepted frames
    `SWCR_ASSERT_NOW(a_ack_status, i_clk, i_rst_n, o_out_valid, o_ack_sent == (o_frame_status == FS_ACCEPTED), "ack_sent disagrees with frame_status")

    // no ACK carries no sequence bit
    `SWCR_ASSERT_NOW(a_ack_seq_zero, i_clk, i_rst_n, o_out_valid && !o_ack_sent, !o_ack_seq, "ack_seq set without an ACK")

    // reset empties the output side
    `SWCR_ASSERT_NEXT_RAW(a_reset_empty, i_clk, !i_rst_n, !o_out_valid, "result beat valid right after reset")

endmodule

bind stop_and_wait_crc_receiver swcr_checker u_swcr_checker (.*);

`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking bench for the stop-and-wait CRC receiver: frame stimulus, prediction, checks.
`timescale 1ns / 1ps

module tb_top;
    import swcr_pkg::*;

    localparam int CRCW        = CRC_WIDTH_DEF;
    localparam int HOLD_CYCLES = 150;    // long receiver hold-off, fills output reg + skid
    localparam int STALL_LIMIT = 2000;   // cycles with work pending and no beat moving
    localparam int PHASE_BITS  = 125;    // random line bits per generator setting
    localparam int PHASE_FRMS  = 5;      // and at least this many frames per setting
    localparam int SETTINGS_N  = 6;

    // One serial line bit as offered on the input channel.
    typedef struct packed {
        logic value;
        logic last;
    } t_line_bit;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // input channel
    logic        in_valid  = 1'b0;
    logic        bit_value = 1'b0;
    logic        last_bit  = 1'b0;
    logic        in_ready;
    // result channel
    logic        out_ready = 1'b0;
    logic        out_valid;
    logic        ack_sent;
    logic        ack_seq;
    logic [1:0]  frame_status;
    // generator register channel
    logic              cfg_valid = 1'b0;
    logic [POLY_W-1:0] cfg_data  = '0;
    logic              cfg_ready;

    stop_and_wait_crc_receiver #(
        .CRC_WIDTH(CRCW)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_bit_value    (bit_value),
        .i_last_bit     (last_bit),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_ack_sent     (ack_sent),
        .o_ack_seq      (ack_seq),
        .o_frame_status (frame_status),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Synchronous reset, held from time zero and released once.
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ---------------------------------------------------------------
    // Shared bench state
    // ---------------------------------------------------------------
    t_line_bit         line_bits_q[$];   // bits waiting to be driven
    logic [POLY_W-1:0] poly_writes_q[$]; // generator writes waiting to be driven
    t_result           verdict_q[$];     // predicted result beats, oldest first

    int bits_accepted  = 0;
    int mismatch_count = 0;
    int hold_left      = 0;
    logic hold_done    = 1'b0;

    // Both sides run without gaps for a stretch in the middle of the run.
    wire calm_stretch = (bits_accepted >= 300) && (bits_accepted < 450);

    // Predictor copy of the receiver state.
    logic            rx_expected_seq;
    logic [CRCW-1:0] rx_remainder;
    logic            rx_at_start;
    logic            rx_seq_ok;
    logic [CRCW-1:0] rx_poly;

    // Stimulus-side view: which sequence bit the receiver wants next and the
    // generator it currently divides by, so frames can be built well-formed.
    logic            gen_seq  = 1'b0;
    logic [CRCW-1:0] gen_poly = POLY_RESET[CRCW-1:0];

    // ---------------------------------------------------------------
    // Divider and predictor
    // ---------------------------------------------------------------

    // One step of the serial divider by x^CRCW + poly.
    function automatic logic [CRCW-1:0] crc_shift(logic [CRCW-1:0] rem, logic b,
                                                 logic [CRCW-1:0] poly);
        return {rem[CRCW-2:0], b} ^ (rem[CRCW-1] ? poly : '0);
    endfunction

    // Advance the predicted receiver by one accepted line bit; a last bit
    // queues the verdict the block must produce for the frame.
    task automatic take_line_bit(logic b, logic last);
        t_result v;
        if (rx_at_start) begin
            rx_seq_ok   = (b == rx_expected_seq);
            rx_at_start = 1'b0;
        end else begin
            rx_remainder = crc_shift(rx_remainder, b, rx_poly);
        end
        if (last) begin
            v.ack_sent = 1'b0;
            v.ack_seq  = 1'b0;
            // mismatch wins over a bad remainder
            if (!rx_seq_ok) begin
                v.status = FS_SEQ_MISMATCH;
            end else if (rx_remainder != '0) begin
                v.status = FS_CRC_ERROR;
            end else begin
                v.ack_sent      = 1'b1;
                v.ack_seq       = rx_expected_seq;
                v.status        = FS_ACCEPTED;
                rx_expected_seq = ~rx_expected_seq;
            end
            verdict_q.push_back(v);
            rx_remainder = '0;
            rx_at_start  = 1'b1;
            rx_seq_ok    = 1'b0;
        end
    endtask

    task automatic note_mismatch(string what, int got, int want);
        $display("ERROR @%0t %s: got %0d, want %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // ---------------------------------------------------------------
    // Stimulus building
    // ---------------------------------------------------------------

    // Queue one frame: sequence bit, then body. Tracks whether the receiver
    // will take it so later well-formed frames carry the right sequence bit.
    task automatic queue_frame(logic seq, logic body[$]);
        logic [CRCW-1:0] rem;
        t_line_bit       lb;
        rem = '0;
        foreach (body[i]) rem = crc_shift(rem, body[i], gen_poly);
        if (seq == gen_seq && rem == '0) gen_seq = ~gen_seq;
        lb.value = seq;
        lb.last  = (body.size() == 0);
        line_bits_q.push_back(lb);
        foreach (body[i]) begin
            lb.value = body[i];
            lb.last  = (i == body.size() - 1);
            line_bits_q.push_back(lb);
        end
    endtask

    // Mostly good frames with random data; some duplicates, some with a
    // flipped bit, some pure noise. Data lengths are mostly short.
    task automatic queue_random_frame(output int n_bits);
        logic            body[$];
        logic [CRCW-1:0] rem;
        logic            seq;
        int              kind;
        int              dlen;
        int              pos;
        kind = $urandom_range(0, 99);
        dlen = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        repeat (dlen) body.push_back(1'($urandom_range(0, 1)));
        if (kind < 90) begin
            // append the check bits: data * x^CRCW mod g, top bit first
            rem = '0;
            foreach (body[i]) rem = crc_shift(rem, body[i], gen_poly);
            repeat (CRCW) rem = crc_shift(rem, 1'b0, gen_poly);
            for (int i = CRCW - 1; i >= 0; i--) body.push_back(rem[i]);
        end
        if (kind < 70) begin
            seq = gen_seq;
        end else if (kind < 80) begin
            seq = ~gen_seq;                 // duplicate of the last taken frame
        end else if (kind < 90) begin
            seq = gen_seq;
            pos = $urandom_range(0, body.size() - 1);
            body[pos] = ~body[pos];         // corrupted on the line
        end else begin
            seq = 1'($urandom_range(0, 1)); // noise, no check bits
        end
        n_bits = body.size() + 1;
        queue_frame(seq, body);
    endtask

    // Directed frames: single-bit frames, short bodies, mismatch priority.
    task automatic queue_directed_frames();
        logic body[$];
        body = {};
        queue_frame(1'b0, body);            // single bit, match -> ACK 0
        queue_frame(1'b0, body);            // single bit, duplicate
        queue_frame(1'b1, body);            // single bit, match -> ACK 1
        body = {1'b1};
        queue_frame(1'b0, body);            // short body, nonzero -> CRC error
        body = {1'b0, 1'b0, 1'b0};
        queue_frame(1'b0, body);            // short all-zero body -> ACK 0
        body = {1'b1};
        queue_frame(1'b0, body);            // duplicate with bad body -> mismatch
    endtask

    task automatic wait_link_idle();
        while (line_bits_q.size() != 0 || in_valid || verdict_q.size() != 0)
            @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Test sequence: one phase per generator setting.
    // ---------------------------------------------------------------
    initial begin : run_phases
        logic [POLY_W-1:0] poly_plan[SETTINGS_N];
        int                phase_bits;
        int                phase_frames;
        int                n;
        poly_plan[0] = POLY_RESET;          // first phase runs on the reset value
        poly_plan[1] = 16'h0000;
        poly_plan[2] = 16'hFFFF;
        poly_plan[3] = 16'($urandom_range(0, 65535));
        poly_plan[4] = 16'h8005;
        poly_plan[5] = POLY_RESET;

        while (!i_rst_n) @(posedge i_clk);

        for (int ph = 0; ph < SETTINGS_N; ph++) begin
            if (ph > 0) begin
                // only touch the register with the link quiet
                wait_link_idle();
                repeat (4) @(posedge i_clk);
                poly_writes_q.push_back(poly_plan[ph]);
                gen_poly = poly_plan[ph][CRCW-1:0];
                while (poly_writes_q.size() != 0 || cfg_valid) @(posedge i_clk);
            end
            if (ph == 0) queue_directed_frames();
            phase_bits   = 0;
            phase_frames = 0;
            while (phase_bits < PHASE_BITS || phase_frames < PHASE_FRMS) begin
                queue_random_frame(n);
                phase_bits += n;
                phase_frames++;
            end
        end

        wait_link_idle();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // ---------------------------------------------------------------
    // Bit driver: predicts on each accepted beat, then offers the next bit
    // or idles about one cycle in five outside the calm stretch.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : drive_bits
        t_line_bit nxt;
        logic      pause;
        if (!i_rst_n) begin
            in_valid        <= 1'b0;
            rx_expected_seq = 1'b0;
            rx_remainder    = '0;
            rx_at_start     = 1'b1;
            rx_seq_ok       = 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                take_line_bit(bit_value, last_bit);
                bits_accepted++;
            end
            // valid holds with its payload until the beat is taken
            if (!in_valid || in_ready) begin
                pause = !calm_stretch && ($urandom_range(0, 99) < 20);
                if (line_bits_q.size() != 0 && !pause) begin
                    nxt       = line_bits_q.pop_front();
                    in_valid  <= 1'b1;
                    bit_value <= nxt.value;
                    last_bit  <= nxt.last;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Generator register writes; the predictor switches on the accepted beat.
    always @(posedge i_clk) begin : drive_poly
        if (!i_rst_n) begin
            cfg_valid <= 1'b0;
            rx_poly   = POLY_RESET[CRCW-1:0];
        end else begin
            if (cfg_valid && cfg_ready) rx_poly = cfg_data[CRCW-1:0];
            if (!cfg_valid || cfg_ready) begin
                if (poly_writes_q.size() != 0) begin
                    cfg_valid <= 1'b1;
                    cfg_data  <= poly_writes_q.pop_front();
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Result monitor: checks each result beat against the oldest verdict,
    // and drives ready with random stalls plus one long hold-off early on.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : watch_results
        t_result want;
        logic    nxt_ready;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (verdict_q.size() == 0) begin
                    note_mismatch("result beat with no frame ended", frame_status, -1);
                end else begin
                    want = verdict_q.pop_front();
                    if (ack_sent !== want.ack_sent)
                        note_mismatch("ack_sent", ack_sent, want.ack_sent);
                    if (ack_seq !== want.ack_seq)
                        note_mismatch("ack_seq", ack_seq, want.ack_seq);
                    if (frame_status !== want.status)
                        note_mismatch("frame_status", frame_status, want.status);
                end
            end
            // hold-off: sender keeps going until the block backs up its input
            if (hold_left > 0) begin
                hold_left--;
                nxt_ready = 1'b0;
            end else if (!hold_done && bits_accepted >= 40) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                nxt_ready = 1'b0;
            end else begin
                nxt_ready = calm_stretch || ($urandom_range(0, 99) >= 20);
            end
            out_ready <= nxt_ready;
        end
    end

    // ---------------------------------------------------------------
    // Watchdog: no beat on any channel for too long while work is pending.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : watchdog
        int   stalled;
        logic pending;
        logic moved;
        if (!i_rst_n) begin
            stalled = 0;
        end else begin
            pending = line_bits_q.size() != 0 || in_valid || verdict_q.size() != 0
                      || poly_writes_q.size() != 0 || cfg_valid;
            moved   = (in_valid && in_ready) || (out_valid && out_ready)
                      || (cfg_valid && cfg_ready);
            if (pending && !moved) stalled++;
            else                   stalled = 0;
            if (stalled >= STALL_LIMIT) begin
                $display("watchdog: no progress for %0d cycles at %0t, %0d results outstanding",
                         stalled, $time, verdict_q.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

endmodule

/* stop_and_wait_crc_receiver.f */
+incdir+src
src/swcr_pkg.sv
src/swcr_cell.sv
src/swcr_crc_row.sv
src/swcr_frame_ctrl.sv
src/stop_and_wait_crc_receiver.sv
src/swcr_checker.sv
tb/sv/tb_top.sv
